@@ src/rqmp_pkg.sv @@
// Shared types and codes for the ready queue min-priority unit.
// No dependencies; used by rqmp_ctrl, rqmp_dp and the top level.
package rqmp_pkg;

  // Request codes
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_RMID   = 2'd2;
  localparam logic [1:0] REQ_RMSLOT = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request word, restart scan
    logic step;    // examine one table entry
    logic commit;  // update table, load result register
  } rqmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // every live entry examined
  } rqmp_sts_t;

endpackage

@@ src/rqmp_ctrl.sv @@
// Controller FSM for the ready queue: sequences load, scan and commit.
// Depends on rqmp_pkg.
module rqmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rqmp_pkg::rqmp_sts_t sts,
  output rqmp_pkg::rqmp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;

  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.step   = (state_r == S_SCAN) && !sts.scan_done;
  assign cmd.commit = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ src/rqmp_dp.sv @@
// Datapath: entry table, scan unit (first id match, oldest minimum),
// one-step compaction and the result register. Depends on rqmp_pkg.
module rqmp_dp #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rqmp_pkg::rqmp_cmd_t cmd,
  output rqmp_pkg::rqmp_sts_t sts,
  input  logic [1:0]          in_req_type,
  input  logic [15:0]         in_pid,
  input  logic [7:0]          in_prio,
  input  logic [3:0]          in_slot_index,
  output logic [1:0]          out_status,
  output logic [15:0]         out_pid,
  output logic [7:0]          out_prio,
  output logic [4:0]          out_count,
  output logic                out_is_empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // request word
  logic [1:0]    req_r;
  logic [15:0]   pid_r;
  logic [7:0]    prio_r;
  logic [3:0]    slot_r;

  // table
  logic [15:0]   ids_r   [DEPTH];
  logic [7:0]    prios_r [DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // scan state
  logic [CW-1:0] scan_idx_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] best_idx_r;
  logic [7:0]    best_prio_r;

  // result register
  logic [1:0]    status_r;
  logic [15:0]   rid_r;
  logic [7:0]    rprio_r;
  logic [4:0]    rcount_r;
  logic          rempty_r;

  logic [IW-1:0]   cur;
  logic            full;
  logic            slot_ok;
  logic [IW+3:0]   slot_wide;
  logic            take;
  logic            enq;
  logic [IW-1:0]   pos;
  logic [1:0]      status_nxt;
  logic [CW+4:0]   count_wide;

  assign cur           = scan_idx_r[IW-1:0];
  assign sts.scan_done = (scan_idx_r >= count_r);
  assign full          = (count_r >= CW'(DEPTH));
  assign slot_ok       = ({{CW{1'b0}}, slot_r} < {4'b0000, count_r});
  assign slot_wide     = {{IW{1'b0}}, slot_r};

  // decide the outcome of the held request
  always_comb begin
    take       = 1'b0;
    enq        = 1'b0;
    pos        = best_idx_r;
    status_nxt = rqmp_pkg::ST_OK;
    case (req_r)
      rqmp_pkg::REQ_ENQ: begin
        if (full) begin
          status_nxt = rqmp_pkg::ST_FULL;
        end else if (hit_r) begin
          status_nxt = rqmp_pkg::ST_DUP;
        end else begin
          enq = 1'b1;
        end
      end
      rqmp_pkg::REQ_DEQ: begin
        pos = best_idx_r;
        if (count_r == '0) status_nxt = rqmp_pkg::ST_MISS;
        else take = 1'b1;
      end
      rqmp_pkg::REQ_RMID: begin
        pos = hit_idx_r;
        if (hit_r) take = 1'b1;
        else status_nxt = rqmp_pkg::ST_MISS;
      end
      rqmp_pkg::REQ_RMSLOT: begin
        pos = slot_wide[IW-1:0];
        if (slot_ok) take = 1'b1;
        else status_nxt = rqmp_pkg::ST_MISS;
      end
      default: status_nxt = rqmp_pkg::ST_MISS;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (take) count_nxt = count_r - CW'(1);
    else if (enq) count_nxt = count_r + CW'(1);
  end

  assign count_wide = {5'b00000, count_nxt};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req_type;
      pid_r      <= in_pid;
      prio_r     <= in_prio;
      slot_r     <= in_slot_index;
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end else if (cmd.step) begin
      scan_idx_r <= scan_idx_r + CW'(1);
      if (!hit_r && ids_r[cur] == pid_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cur;
      end
      // strict less keeps the oldest entry on a tie
      if (scan_idx_r == '0 || prios_r[cur] < best_prio_r) begin
        best_idx_r  <= cur;
        best_prio_r <= prios_r[cur];
      end
    end
  end

  // table update: append at tail or close up behind the removed slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (take && j < DEPTH - 1 && IW'(j) >= pos) begin
          ids_r[j]   <= ids_r[(j + 1) % DEPTH];
          prios_r[j] <= prios_r[(j + 1) % DEPTH];
        end else if (enq && count_r == CW'(j)) begin
          ids_r[j]   <= pid_r;
          prios_r[j] <= prio_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      rid_r    <= take ? ids_r[pos] : 16'd0;
      rprio_r  <= take ? prios_r[pos] : 8'd0;
      rcount_r <= count_wide[4:0];
      rempty_r <= (count_nxt == '0);
    end
  end

  assign out_status   = status_r;
  assign out_pid      = rid_r;
  assign out_prio     = rprio_r;
  assign out_count    = rcount_r;
  assign out_is_empty = rempty_r;

endmodule

@@ src/ready_queue_min_priority_unit.sv @@
// Top level of the ready queue min-priority unit.
// Depends on rqmp_pkg, rqmp_ctrl and rqmp_dp.
//
// Usage:
//  - Request channel (in_*): one word per request: type, pid, prio, slot.
//    A word is taken on a rising edge with in_valid high and in_stall low.
//  - Result channel (out_*): exactly one word per request with status,
//    removed pid/prio (zero when nothing was removed), count after the
//    request and an empty flag. Taken when out_valid high, out_stall low.
//  - Sequence: an accepted request is loaded, its scan then examines the
//    live entries at one entry per cycle, the scan end is checked, and
//    the request commits its result. The scan unit is the limiting part:
//    one request is in flight at a time, so the next request is taken
//    only after the previous one has committed.
//  - The result sits in its own register; a new request is accepted while
//    the previous result waits. A request that finishes while the result
//    register is still stalled holds in its commit step until it frees.
//  - Reset (rst_n low, synchronous) empties the table and drops any
//    pending result. Entry storage itself is not cleared; only entries
//    below the count are ever read.
module ready_queue_min_priority_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_pid,
  input  logic [7:0]  in_prio,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_pid,
  output logic [7:0]  out_prio,
  output logic [4:0]  out_count,
  output logic        out_is_empty
);

  rqmp_pkg::rqmp_cmd_t cmd;
  rqmp_pkg::rqmp_sts_t sts;

  // sequencing: idle -> scan -> commit
  rqmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, scan unit and result register
  rqmp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_req_type),
    .in_pid        (in_pid),
    .in_prio       (in_prio),
    .in_slot_index (in_slot_index),
    .out_status    (out_status),
    .out_pid       (out_pid),
    .out_prio      (out_prio),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty)
  );

endmodule
